// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the heap queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold outside reset.
`define BHQ_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define BHQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bhq_pkg.sv -----
// Types and constants shared by the heap queue modules.
package bhq_pkg;

  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic valid;
    logic pop;
  } bhq_tok_ctl_t;

endpackage

// ----- rtl/binary_max_heap_queue.sv -----
// Binary max-heap priority queue built as a chain of per-level cells.
//
// Input channel (in_valid/in_ready): opcode selects push of value or pop of the
// largest stored value. Output channel (out_valid/out_ready): one word per input
// word with popped_value, top_value, entry_count and status.
// The store is split by heap level; each level cell owns its entries in a local
// memory of sibling pairs and hands the moving word to the next level below.
// Items are handled one at a time, and the moving word advances one level per
// cycle. A push walks from the root to the new slot. A pop reads the last
// entry, sinks it from the root downwards, then reads the new root; the default
// depth gives levels 0 to 10. Popping the only entry and the errors (pop when
// empty, push when full) go straight to the output and leave the store
// unchanged. in_ready returns in the same cycle as out_valid rises, so a new
// word is taken only once the last result is in the output register.
// The result sits in an output register, so the next word is processed while
// it waits; a stalled receiver holds back the next result and, after that,
// in_ready. Reset empties the queue at once; no memory clearing is needed.
`include "assert_macros.svh"

module binary_max_heap_queue #(
  parameter int HEAP_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 opcode,
  input  logic signed [bhq_pkg::DATA_W-1:0]    value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bhq_pkg::DATA_W-1:0]    popped_value,
  output logic signed [bhq_pkg::DATA_W-1:0]    top_value,
  output logic [bhq_pkg::COUNT_W-1:0]          entry_count,
  output logic [bhq_pkg::STATUS_W-1:0]         status
);
  import bhq_pkg::*;

  localparam int NL    = $clog2(HEAP_DEPTH + 1);
  localparam int IDX_W = NL;
  localparam int LVL_W = $clog2(NL + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUSH  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_SIFT  = 3'd3;
  localparam logic [2:0] S_ROOT  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]               state;
  logic [IDX_W-1:0]         count;
  logic [LVL_W-1:0]         cnt_lvl;
  logic [IDX_W-1:0]         cnt_slot;
  logic signed [DATA_W-1:0] top;
  logic signed [DATA_W-1:0] res_popped;
  logic [STATUS_W-1:0]      res_status;
  logic [LVL_W-1:0]         fin_lvl;
  logic [IDX_W-1:0]         fin_slot;
  bhq_tok_ctl_t             tok0;
  bhq_tok_ctl_t             tok1;
  logic signed [DATA_W-1:0] tok_value;
  logic                     probe_v;
  logic [LVL_W-1:0]         probe_lvl;
  logic [IDX_W-1:0]         probe_slot;

  logic [IDX_W:0]           lvl_pow;
  logic                     at_lvl_end;
  logic [LVL_W-1:0]         inc_lvl;
  logic [IDX_W-1:0]         inc_slot;
  logic [LVL_W-1:0]         dec_lvl;
  logic [IDX_W-1:0]         dec_slot;

  bhq_tok_ctl_t             tok_o_ctl  [NL];
  logic [IDX_W-1:0]         tok_o_slot [NL];
  logic signed [DATA_W-1:0] tok_o_val  [NL];
  logic                     wb_o_we    [NL];
  logic [IDX_W-1:0]         wb_o_slot  [NL];
  logic signed [DATA_W-1:0] wb_o_val   [NL];
  logic                     done_v     [NL];
  logic                     pv         [NL];
  logic signed [DATA_W-1:0] pd         [NL];

  logic                     any_done;
  logic                     any_pv;
  logic signed [DATA_W-1:0] pdata;

  assign in_ready = (state == S_IDLE);

  // Level and in-level slot of the next free position track the count.
  assign lvl_pow    = (IDX_W+1)'(1) << cnt_lvl;
  assign at_lvl_end = (cnt_slot == IDX_W'(lvl_pow - 1'b1));
  assign inc_lvl    = at_lvl_end ? cnt_lvl + 1'b1 : cnt_lvl;
  assign inc_slot   = at_lvl_end ? '0 : cnt_slot + 1'b1;
  assign dec_lvl    = (cnt_slot == '0) ? cnt_lvl - 1'b1 : cnt_lvl;
  assign dec_slot   = (cnt_slot == '0) ? IDX_W'((lvl_pow >> 1) - 1'b1) : cnt_slot - 1'b1;

  always_comb begin
    any_done = 1'b0;
    any_pv   = 1'b0;
    pdata    = '0;
    for (int k = 0; k < NL; k++) begin
      if (done_v[k]) begin
        any_done = 1'b1;
      end
      if (pv[k]) begin
        any_pv = 1'b1;
        pdata  = pd[k];
      end
    end
  end

  for (genvar j = 0; j < NL; j++) begin : g_lvl
    localparam int SPAN = (HEAP_DEPTH - ((1 << j) - 1) + 1) / 2;
    localparam int HALF = (1 << j) >> 1;
    localparam int ROWS = (j == 0) ? 1 : ((HALF < SPAN) ? HALF : SPAN);

    bhq_tok_ctl_t             ci_ctl;
    logic [IDX_W-1:0]         ci_slot;
    logic signed [DATA_W-1:0] ci_val;
    logic                     wi_we;
    logic [IDX_W-1:0]         wi_slot;
    logic signed [DATA_W-1:0] wi_val;

    if (j == 0) begin : g_head
      assign ci_ctl  = tok0;
      assign ci_slot = '0;
      assign ci_val  = tok_value;
    end else if (j == 1) begin : g_second
      // A pop starts its sift here, with the root as the parent.
      assign ci_ctl  = tok1.valid ? tok1 : tok_o_ctl[0];
      assign ci_slot = tok1.valid ? '0 : tok_o_slot[0];
      assign ci_val  = tok1.valid ? tok_value : tok_o_val[0];
    end else begin : g_mid
      assign ci_ctl  = tok_o_ctl[j-1];
      assign ci_slot = tok_o_slot[j-1];
      assign ci_val  = tok_o_val[j-1];
    end

    if (j == NL - 1) begin : g_tail
      assign wi_we   = 1'b0;
      assign wi_slot = '0;
      assign wi_val  = '0;
    end else begin : g_body
      assign wi_we   = wb_o_we[j+1];
      assign wi_slot = wb_o_slot[j+1];
      assign wi_val  = wb_o_val[j+1];
    end

    bhq_level_cell #(
      .LEVEL (j),
      .IDX_W (IDX_W),
      .LVL_W (LVL_W),
      .ROWS  (ROWS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .tok_in_ctl    (ci_ctl),
      .tok_in_slot   (ci_slot),
      .tok_in_value  (ci_val),
      .tok_out_ctl   (tok_o_ctl[j]),
      .tok_out_slot  (tok_o_slot[j]),
      .tok_out_value (tok_o_val[j]),
      .wb_in_we      (wi_we),
      .wb_in_slot    (wi_slot),
      .wb_in_value   (wi_val),
      .wb_out_we     (wb_o_we[j]),
      .wb_out_slot   (wb_o_slot[j]),
      .wb_out_value  (wb_o_val[j]),
      .fin_lvl       (fin_lvl),
      .fin_slot      (fin_slot),
      .new_count     (count),
      .probe_valid   (probe_v),
      .probe_lvl     (probe_lvl),
      .probe_slot    (probe_slot),
      .probe_hit     (pv[j]),
      .probe_data    (pd[j]),
      .done          (done_v[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cnt_lvl   <= '0;
      cnt_slot  <= '0;
      top       <= '0;
      out_valid <= 1'b0;
      tok0      <= '0;
      tok1      <= '0;
      probe_v   <= 1'b0;
    end else begin
      tok0    <= '0;
      tok1    <= '0;
      probe_v <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_popped <= '0;
            res_status <= ST_OK;
            if (opcode == OP_PUSH) begin
              if (count == IDX_W'(HEAP_DEPTH)) begin
                res_status <= ST_FULL;
                state      <= S_OUT;
              end else begin
                tok0      <= '{valid: 1'b1, pop: OP_PUSH};
                tok_value <= value;
                fin_lvl   <= cnt_lvl;
                fin_slot  <= cnt_slot;
                count     <= count + 1'b1;
                cnt_lvl   <= inc_lvl;
                cnt_slot  <= inc_slot;
                if ((count == '0) || (value > top)) begin
                  top <= value;
                end
                state <= S_PUSH;
              end
            end else begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_OUT;
              end else begin
                res_popped <= top;
                count      <= count - 1'b1;
                cnt_lvl    <= dec_lvl;
                cnt_slot   <= dec_slot;
                if (count == IDX_W'(1)) begin
                  top   <= '0;
                  state <= S_OUT;
                end else begin
                  // Fetch the last entry; it refills the root.
                  probe_v    <= 1'b1;
                  probe_lvl  <= dec_lvl;
                  probe_slot <= dec_slot;
                  state      <= S_FETCH;
                end
              end
            end
          end
        end
        S_PUSH: begin
          if (any_done) begin
            state <= S_OUT;
          end
        end
        S_FETCH: begin
          if (any_pv) begin
            tok1      <= '{valid: 1'b1, pop: OP_POP};
            tok_value <= pdata;
            state     <= S_SIFT;
          end
        end
        S_SIFT: begin
          if (any_done) begin
            probe_v    <= 1'b1;
            probe_lvl  <= '0;
            probe_slot <= '0;
            state      <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (any_pv) begin
            top   <= pdata;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!out_valid || out_ready)) begin
      popped_value <= res_popped;
      top_value    <= top;
      entry_count  <= COUNT_W'(count);
      status       <= res_status;
    end
  end

  `BHQ_ASSERT_NEVER(a_no_token_past_last, tok_o_ctl[NL-1].valid, "token left the last level")
  `BHQ_ASSERT_NEVER(a_no_root_writeback, wb_o_we[0], "root level issued a parent write")
  `BHQ_ASSERT_NEVER(a_count_bound, count > IDX_W'(HEAP_DEPTH), "entry count above depth")
  `BHQ_ASSERT_IMPLY(a_done_when_walking, any_done, (state == S_PUSH) || (state == S_SIFT), "level finished outside a walk")
  `BHQ_ASSERT_NEXT(a_result_loaded, (state == S_OUT) && (!out_valid || out_ready), out_valid, "result not presented")

endmodule

// ----- rtl/bhq_level_cell.sv -----
// One heap level: its share of the store and the compare step for a word passing through.
module bhq_level_cell #(
  parameter int LEVEL = 0,
  parameter int IDX_W = 2,
  parameter int LVL_W = 2,
  parameter int ROWS  = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bhq_pkg::bhq_tok_ctl_t               tok_in_ctl,
  input  logic [IDX_W-1:0]                    tok_in_slot,
  input  logic signed [bhq_pkg::DATA_W-1:0]   tok_in_value,
  output bhq_pkg::bhq_tok_ctl_t               tok_out_ctl,
  output logic [IDX_W-1:0]                    tok_out_slot,
  output logic signed [bhq_pkg::DATA_W-1:0]   tok_out_value,
  input  logic                                wb_in_we,
  input  logic [IDX_W-1:0]                    wb_in_slot,
  input  logic signed [bhq_pkg::DATA_W-1:0]   wb_in_value,
  output logic                                wb_out_we,
  output logic [IDX_W-1:0]                    wb_out_slot,
  output logic signed [bhq_pkg::DATA_W-1:0]   wb_out_value,
  input  logic [LVL_W-1:0]                    fin_lvl,
  input  logic [IDX_W-1:0]                    fin_slot,
  input  logic [IDX_W-1:0]                    new_count,
  input  logic                                probe_valid,
  input  logic [LVL_W-1:0]                    probe_lvl,
  input  logic [IDX_W-1:0]                    probe_slot,
  output logic                                probe_hit,
  output logic signed [bhq_pkg::DATA_W-1:0]   probe_data,
  output logic                                done
);
  import bhq_pkg::*;

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [IDX_W:0] BASE = (IDX_W+1)'((1 << LEVEL) - 1);

  // Each row holds a sibling pair: the low half is the even slot.
  logic [2*DATA_W-1:0] mem [ROWS];
  logic [2*DATA_W-1:0] rd;

  logic                     busy;
  logic                     op_pop;
  logic                     probe_pend;
  logic                     probe_half;
  logic [IDX_W-1:0]         slot_r;
  logic signed [DATA_W-1:0] val_r;
  logic                     probe_now;

  logic signed [DATA_W-1:0] lo;
  logic signed [DATA_W-1:0] hi;
  logic signed [DATA_W-1:0] own_old;
  logic signed [DATA_W-1:0] keep;
  logic signed [DATA_W-1:0] pass;
  logic signed [DATA_W-1:0] cval;
  logic [IDX_W:0]           lpos;
  logic [IDX_W:0]           rpos;
  logic [IDX_W:0]           cpos;
  logic [IDX_W+1:0]         gpos;
  logic                     left_ok;
  logic                     right_ok;
  logic                     pick_right;
  logic                     grand_ok;
  logic [LVL_W-1:0]         shamt;
  logic [IDX_W-1:0]         path_sh;

  logic                     own_we;
  logic [ROW_W-1:0]         own_row;
  logic [2*DATA_W-1:0]      own_data;

  assign lo = rd[DATA_W-1:0];
  assign hi = rd[2*DATA_W-1:DATA_W];
  assign probe_now = probe_valid && (probe_lvl == LVL_W'(LEVEL));

  assign probe_hit  = probe_pend;
  assign probe_data = probe_half ? hi : lo;

  always_comb begin
    lpos       = BASE + {slot_r, 1'b0};
    rpos       = lpos + 1'b1;
    left_ok    = lpos < {1'b0, new_count};
    right_ok   = rpos < {1'b0, new_count};
    // The left child wins a tie.
    pick_right = right_ok && (hi > lo);
    cval       = pick_right ? hi : lo;
    cpos       = pick_right ? rpos : lpos;
    gpos       = {cpos, 1'b1};
    grand_ok   = gpos < {2'b00, new_count};
    own_old    = slot_r[0] ? hi : lo;
    keep       = (val_r > own_old) ? val_r : own_old;
    pass       = (val_r > own_old) ? own_old : val_r;
    shamt      = fin_lvl - LVL_W'(LEVEL) - LVL_W'(1);
    path_sh    = fin_slot >> shamt;

    own_we        = 1'b0;
    own_row       = '0;
    own_data      = rd;
    tok_out_ctl   = '0;
    tok_out_slot  = '0;
    tok_out_value = val_r;
    wb_out_we     = 1'b0;
    wb_out_slot   = slot_r;
    wb_out_value  = val_r;
    done          = 1'b0;

    if (busy) begin
      if (!op_pop) begin
        own_we  = 1'b1;
        own_row = slot_r[ROW_W:1];
        if (fin_lvl == LVL_W'(LEVEL)) begin
          own_data = slot_r[0] ? {val_r, lo} : {hi, val_r};
          done     = 1'b1;
        end else begin
          // The larger value stays on the path; the smaller one moves on.
          own_data      = slot_r[0] ? {keep, lo} : {hi, keep};
          tok_out_ctl   = '{valid: 1'b1, pop: OP_PUSH};
          tok_out_slot  = {slot_r[IDX_W-2:0], path_sh[0]};
          tok_out_value = pass;
        end
      end else begin
        wb_out_we = 1'b1;
        if (!left_ok || (val_r >= cval)) begin
          wb_out_value = val_r;
          done         = 1'b1;
        end else begin
          wb_out_value = cval;
          if (grand_ok) begin
            tok_out_ctl   = '{valid: 1'b1, pop: OP_POP};
            tok_out_slot  = {slot_r[IDX_W-2:0], pick_right};
            tok_out_value = val_r;
          end else begin
            // The chosen child is a leaf, so the sinking value lands here.
            own_we   = 1'b1;
            own_row  = slot_r[ROW_W-1:0];
            own_data = pick_right ? {val_r, lo} : {hi, val_r};
            done     = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      probe_pend <= 1'b0;
    end else begin
      busy       <= tok_in_ctl.valid;
      probe_pend <= probe_now;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in_ctl.valid) begin
      slot_r <= tok_in_slot;
      val_r  <= tok_in_value;
      op_pop <= tok_in_ctl.pop;
    end
    if (probe_now) begin
      probe_half <= probe_slot[0];
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in_ctl.valid) begin
      rd <= mem[tok_in_ctl.pop ? tok_in_slot[ROW_W-1:0] : tok_in_slot[ROW_W:1]];
    end else if (probe_now) begin
      rd <= mem[probe_slot[ROW_W:1]];
    end
    if (own_we) begin
      mem[own_row] <= own_data;
    end else if (wb_in_we) begin
      // The sibling half still sits in rd from this level's own read.
      mem[wb_in_slot[ROW_W:1]] <= wb_in_slot[0] ? {wb_in_value, lo} : {hi, wb_in_value};
    end
  end

endmodule

// ----- verif/heap_checker.sv -----
// Checker for the heap queue: shadow heap, expected result queue and comparison.
module heap_checker #(
  parameter int HEAP_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               opcode,
  input  logic signed [bhq_pkg::DATA_W-1:0]  value,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [bhq_pkg::DATA_W-1:0]  popped_value,
  input  logic signed [bhq_pkg::DATA_W-1:0]  top_value,
  input  logic [bhq_pkg::COUNT_W-1:0]        entry_count,
  input  logic [bhq_pkg::STATUS_W-1:0]       status,
  output int                                 fail_count,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bhq_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped;
    logic signed [DATA_W-1:0] top;
    logic [COUNT_W-1:0]       count;
    logic [STATUS_W-1:0]      status;
  } heap_result_t;

  logic signed [DATA_W-1:0] shadow_heap [HEAP_DEPTH];
  int                       shadow_count;
  heap_result_t             expected_results [$];

  initial begin
    fail_count = 0;
    pending = 0;
    shadow_count = 0;
  end

  // Applies one push or pop to the shadow heap and returns the word it should produce.
  function automatic heap_result_t apply_heap_op(logic op, logic signed [DATA_W-1:0] v);
    heap_result_t r;
    logic signed [DATA_W-1:0] tmp;
    int pos;
    int parent;
    int left;
    int right;
    int pick;
    r = '0;
    r.status = ST_OK;
    if (op == OP_PUSH) begin
      if (shadow_count >= HEAP_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = shadow_count;
        shadow_heap[pos] = v;
        shadow_count++;
        // Rise while the parent is strictly smaller.
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (shadow_heap[parent] >= shadow_heap[pos]) break;
          tmp = shadow_heap[parent];
          shadow_heap[parent] = shadow_heap[pos];
          shadow_heap[pos] = tmp;
          pos = parent;
        end
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped = shadow_heap[0];
        shadow_count--;
        if (shadow_count > 0) begin
          shadow_heap[0] = shadow_heap[shadow_count];
          pos = 0;
          forever begin
            left = 2 * pos + 1;
            right = left + 1;
            if (left >= shadow_count) break;
            if (right >= shadow_count) begin
              if (shadow_heap[pos] < shadow_heap[left]) begin
                tmp = shadow_heap[pos];
                shadow_heap[pos] = shadow_heap[left];
                shadow_heap[left] = tmp;
              end
              break;
            end
            if (shadow_heap[pos] >= shadow_heap[left] &&
                shadow_heap[pos] >= shadow_heap[right]) break;
            // Equal children go to the left one.
            pick = (shadow_heap[left] >= shadow_heap[right]) ? left : right;
            tmp = shadow_heap[pos];
            shadow_heap[pos] = shadow_heap[pick];
            shadow_heap[pick] = tmp;
            pos = pick;
          end
        end
      end
    end
    r.top = (shadow_count > 0) ? shadow_heap[0] : '0;
    r.count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [DATA_W-1:0] exp_v,
                                      logic signed [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    heap_result_t exp_r;
    if (!rst) begin
      // Results are checked before the same-edge input is predicted.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, popped %0d top %0d count %0d status %0d",
                   $time, popped_value, top_value, entry_count, status);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("popped_value", exp_r.popped, popped_value);
          check_field("top_value", exp_r.top, top_value);
          check_field("entry_count", DATA_W'(exp_r.count), DATA_W'(entry_count));
          check_field("status", DATA_W'(exp_r.status), DATA_W'(status));
        end
      end
      if (in_valid && in_ready) expected_results.push_back(apply_heap_op(opcode, value));
      pending = expected_results.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// Top of the heap queue testbench: clock, reset, stimulus, watchdog and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bhq_pkg::*;

  localparam int HEAP_DEPTH  = 1024;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 60;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      opcode = OP_PUSH;
  logic signed [DATA_W-1:0]  value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [DATA_W-1:0]  popped_value;
  logic signed [DATA_W-1:0]  top_value;
  logic [COUNT_W-1:0]        entry_count;
  logic [STATUS_W-1:0]       status;
  int                        fail_count;
  int                        pending;

  // When set, neither side inserts idle cycles.
  bit steady = 1'b0;
  int sent_words = 0;
  int stim_count = 0;

  binary_max_heap_queue #(.HEAP_DEPTH(HEAP_DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .popped_value(popped_value), .top_value(top_value),
    .entry_count(entry_count), .status(status)
  );

  heap_checker #(.HEAP_DEPTH(HEAP_DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .popped_value(popped_value), .top_value(top_value),
    .entry_count(entry_count), .status(status),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic op, input logic signed [DATA_W-1:0] v);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (op == OP_PUSH && stim_count < HEAP_DEPTH) stim_count++;
    if (op == OP_POP && stim_count > 0) stim_count--;
    sent_words++;
    if (sent_words % 50 == 0) steady = ($urandom_range(0, 4) == 0);
  endtask

  // Many small values so that equal keys meet often, plus extremes and full-range words.
  function automatic logic signed [DATA_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return DATA_W'(int'($urandom_range(0, 15)) - 8);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random(input int pop_weight);
    logic op;
    op = ($urandom_range(0, 99) < pop_weight) ? OP_POP : OP_PUSH;
    send_word(op, draw_value());
  endtask

  // Receiver: draws a stall before each result word.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty pops, extremes, equal keys on both sift directions, drain to empty.
    send_word(OP_POP, 32'sd0);
    send_word(OP_PUSH, 32'sd0);
    send_word(OP_POP, 32'sh7FFF_FFFF);
    send_word(OP_POP, -32'sd1);
    send_word(OP_PUSH, 32'sh7FFF_FFFF);
    send_word(OP_PUSH, 32'sh8000_0000);
    send_word(OP_PUSH, -32'sd1);
    send_word(OP_PUSH, 32'sd1);
    send_word(OP_PUSH, 32'sd3);
    send_word(OP_PUSH, 32'sd3);
    send_word(OP_PUSH, 32'sd3);
    send_word(OP_POP, 32'sd0);
    send_word(OP_POP, 32'sd0);
    send_word(OP_PUSH, 32'sh8000_0000);
    send_word(OP_PUSH, 32'sh7FFF_FFFF);
    while (stim_count > 0) send_word(OP_POP, $urandom());
    send_word(OP_POP, 32'sh8000_0000);

    // Balanced mix that keeps the store shallow and often empty.
    repeat (400) send_random(50);
    // Fill to capacity, then keep pushing into the full store.
    while (stim_count < HEAP_DEPTH) send_random(5);
    repeat (6) send_word(OP_PUSH, draw_value());
    // Mostly pops from a deep heap.
    repeat (500) send_random(80);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
